/* rtl/core/phbc_pkg.sv */
`default_nettype none

package phbc_pkg;

	// Fixed field widths.
	localparam int COEF_BITS     = 18;
	localparam int TRANS_BITS    = 16;
	localparam int BAND_BITS     = 14;
	localparam int MARGIN_BITS   = 13;
	localparam int DEC_BITS      = 8;
	localparam int OUT_BITS      = 15;
	localparam int ROW_BITS      = 3 * COEF_BITS;
	localparam int XLAT_BITS     = 3 * TRANS_BITS;
	localparam int CFG_DATA_BITS = ROW_BITS;
	localparam int CFG_IDX_BITS  = 3;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ROT_ROW_X    = 3'd0,
		REG_ROT_ROW_Y    = 3'd1,
		REG_ROT_ROW_Z    = 3'd2,
		REG_TRANSLATION  = 3'd3,
		REG_BAND_LOW     = 3'd4,
		REG_BAND_HIGH    = 3'd5,
		REG_UPPER_MARGIN = 3'd6,
		REG_DECIMATION   = 3'd7
	} cfg_reg_t;

	// Reset values of the registers.
	localparam logic [ROW_BITS-1:0]    RST_ROT_ROW_X    = 54'd65536;
	localparam logic [ROW_BITS-1:0]    RST_ROT_ROW_Y    = 54'd17179869184;
	localparam logic [ROW_BITS-1:0]    RST_ROT_ROW_Z    = 54'd4503599627370496;
	localparam logic [XLAT_BITS-1:0]   RST_TRANSLATION  = 48'd0;
	localparam logic [BAND_BITS-1:0]   RST_BAND_LOW     = 14'd700;
	localparam logic [BAND_BITS-1:0]   RST_BAND_HIGH    = 14'd1000;
	localparam logic [MARGIN_BITS-1:0] RST_UPPER_MARGIN = 13'd30;
	localparam logic [DEC_BITS-1:0]    RST_DECIMATION   = 8'd1;

	// Band codes of a result item.
	localparam logic BAND_BASKET = 1'b0;
	localparam logic BAND_ABOVE  = 1'b1;

	typedef struct packed {
		logic [ROW_BITS-1:0]           rot_row_x;
		logic [ROW_BITS-1:0]           rot_row_y;
		logic [ROW_BITS-1:0]           rot_row_z;
		logic [XLAT_BITS-1:0]          translation;
		logic signed [BAND_BITS-1:0]   band_low;
		logic signed [BAND_BITS-1:0]   band_high;
		logic [MARGIN_BITS-1:0]        upper_margin;
		logic [DEC_BITS-1:0]           decimation;
	} cfg_t;

	// Load enables of the transform stages.
	typedef struct packed {
		logic s2_load;
		logic s3_load;
	} pipe_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/phbc_point_if.sv */
`default_nettype none

interface phbc_point_if #(
	parameter int COORD_BITS = 14
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;
	logic                         point_invalid;
	logic                         last_point;

	modport source (
		output valid, point_x, point_y, point_z, point_invalid, last_point,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_z, point_invalid, last_point,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/core/phbc_world_if.sv */
`default_nettype none

interface phbc_world_if
	import phbc_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] world_x;
	logic signed [OUT_BITS-1:0] world_y;
	logic signed [OUT_BITS-1:0] world_z;
	logic                       band;

	modport source (
		output valid, world_x, world_y, world_z, band,
		input  ready
	);
	modport sink (
		input  valid, world_x, world_y, world_z, band,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/core/phbc_cfg.sv */
`default_nettype none

module phbc_cfg
	import phbc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	output cfg_t                          cfg
);

	cfg_t cfg_q;

	// Register file: one register written per enabled cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_row_x    <= RST_ROT_ROW_X;
			cfg_q.rot_row_y    <= RST_ROT_ROW_Y;
			cfg_q.rot_row_z    <= RST_ROT_ROW_Z;
			cfg_q.translation  <= RST_TRANSLATION;
			cfg_q.band_low     <= RST_BAND_LOW;
			cfg_q.band_high    <= RST_BAND_HIGH;
			cfg_q.upper_margin <= RST_UPPER_MARGIN;
			cfg_q.decimation   <= RST_DECIMATION;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROT_ROW_X:    cfg_q.rot_row_x    <= cfg_data[ROW_BITS-1:0];
				REG_ROT_ROW_Y:    cfg_q.rot_row_y    <= cfg_data[ROW_BITS-1:0];
				REG_ROT_ROW_Z:    cfg_q.rot_row_z    <= cfg_data[ROW_BITS-1:0];
				REG_TRANSLATION:  cfg_q.translation  <= cfg_data[XLAT_BITS-1:0];
				REG_BAND_LOW:     cfg_q.band_low     <= cfg_data[BAND_BITS-1:0];
				REG_BAND_HIGH:    cfg_q.band_high    <= cfg_data[BAND_BITS-1:0];
				REG_UPPER_MARGIN: cfg_q.upper_margin <= cfg_data[MARGIN_BITS-1:0];
				REG_DECIMATION:   cfg_q.decimation   <= cfg_data[DEC_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/phbc_xform.sv */
`default_nettype none

module phbc_xform
	import phbc_pkg::*;
#(
	parameter int COORD_BITS = 14,
	parameter int PROD_W     = COEF_BITS + COORD_BITS,
	parameter int ACC_W      = PROD_W + 2
) (
	input  wire logic                         clk,
	input  wire pipe_ctl_t                    ctl,
	input  wire cfg_t                         cfg,
	input  wire logic signed [COORD_BITS-1:0] px,
	input  wire logic signed [COORD_BITS-1:0] py,
	input  wire logic signed [COORD_BITS-1:0] pz,
	output logic signed [ACC_W-1:0]           acc_x,
	output logic signed [ACC_W-1:0]           acc_y,
	output logic signed [ACC_W-1:0]           acc_z
);

	logic [ROW_BITS-1:0]         rows [3];
	logic signed [COORD_BITS-1:0] pts [3];
	logic signed [PROD_W-1:0]    prod_s2 [3][3];
	logic signed [ACC_W-1:0]     acc_s3 [3];

	assign rows[0] = cfg.rot_row_x;
	assign rows[1] = cfg.rot_row_y;
	assign rows[2] = cfg.rot_row_z;
	assign pts[0]  = px;
	assign pts[1]  = py;
	assign pts[2]  = pz;

	// Stage 2: nine coefficient-by-coordinate products, one multiplier each.
	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			logic signed [COEF_BITS-1:0] coef;
			logic signed [PROD_W-1:0]    coef_w;
			logic signed [PROD_W-1:0]    pt_w;

			assign coef   = rows[r][c*COEF_BITS +: COEF_BITS];
			assign coef_w = {{(PROD_W-COEF_BITS){coef[COEF_BITS-1]}}, coef};
			assign pt_w   = {{(PROD_W-COORD_BITS){pts[c][COORD_BITS-1]}}, pts[c]};

			always_ff @(posedge clk) begin
				if (ctl.s2_load) begin
					prod_s2[r][c] <= coef_w * pt_w;
				end
			end
		end

		// Stage 3: row sum of the three products.
		always_ff @(posedge clk) begin
			if (ctl.s3_load) begin
				acc_s3[r] <= {{2{prod_s2[r][0][PROD_W-1]}}, prod_s2[r][0]}
					+ {{2{prod_s2[r][1][PROD_W-1]}}, prod_s2[r][1]}
					+ {{2{prod_s2[r][2][PROD_W-1]}}, prod_s2[r][2]};
			end
		end
	end

	assign acc_x = acc_s3[0];
	assign acc_y = acc_s3[1];
	assign acc_z = acc_s3[2];

endmodule

`default_nettype wire

/* rtl/core/phbc_classify.sv */
`default_nettype none

module phbc_classify
	import phbc_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int ACC_W     = 34
) (
	input  wire cfg_t                   cfg,
	input  wire logic signed [ACC_W-1:0] acc_x,
	input  wire logic signed [ACC_W-1:0] acc_y,
	input  wire logic signed [ACC_W-1:0] acc_z,
	output logic                        hit,
	output logic                        band,
	output logic signed [OUT_BITS-1:0]  world_x,
	output logic signed [OUT_BITS-1:0]  world_y,
	output logic signed [OUT_BITS-1:0]  world_z
);

	// Width of the threshold compare: holds the accumulator and the scaled bounds.
	localparam int BOUND_W = FRAC_BITS + 19;
	localparam int CMP_W   = ((ACC_W > BOUND_W) ? ACC_W : BOUND_W) + 1;
	localparam int SUM_W   = ACC_W + 1;
	localparam int DIFF_W  = TRANS_BITS + 1;

	logic signed [TRANS_BITS-1:0] tx, ty, tz;
	logic signed [DIFF_W-1:0]     diff_low, diff_high;
	logic signed [CMP_W-1:0]      low_th, high_th, up_th, acc_cmp;
	logic signed [SUM_W-1:0]      sum_x, sum_y, sum_z;
	logic                         ge_low, le_high, le_up;

	function automatic logic signed [OUT_BITS-1:0] sat_out(
		input logic signed [SUM_W-1:0] v
	);
		logic ovf;
		ovf = (v[SUM_W-1:OUT_BITS-1] != {(SUM_W-OUT_BITS+1){1'b0}})
			&& (v[SUM_W-1:OUT_BITS-1] != {(SUM_W-OUT_BITS+1){1'b1}});
		if (!ovf) begin
			return v[OUT_BITS-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(OUT_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(OUT_BITS-1){1'b1}}};
		end
	endfunction

	assign tx = cfg.translation[0*TRANS_BITS +: TRANS_BITS];
	assign ty = cfg.translation[1*TRANS_BITS +: TRANS_BITS];
	assign tz = cfg.translation[2*TRANS_BITS +: TRANS_BITS];

	// Band bounds moved into the camera-side height frame, scaled to the accumulator.
	assign diff_low  = {{(DIFF_W-BAND_BITS){cfg.band_low[BAND_BITS-1]}}, cfg.band_low}
		- {tz[TRANS_BITS-1], tz};
	assign diff_high = {{(DIFF_W-BAND_BITS){cfg.band_high[BAND_BITS-1]}}, cfg.band_high}
		- {tz[TRANS_BITS-1], tz};
	assign low_th  = {{(CMP_W-DIFF_W-FRAC_BITS){diff_low[DIFF_W-1]}}, diff_low,
		{FRAC_BITS{1'b0}}};
	assign high_th = {{(CMP_W-DIFF_W-FRAC_BITS){diff_high[DIFF_W-1]}}, diff_high,
		{FRAC_BITS{1'b0}}};
	assign up_th   = high_th + {{(CMP_W-MARGIN_BITS+1-FRAC_BITS){1'b0}},
		cfg.upper_margin[MARGIN_BITS-1:1], {FRAC_BITS{1'b0}}};
	assign acc_cmp = {{(CMP_W-ACC_W){acc_z[ACC_W-1]}}, acc_z};

	// Height classification at full precision.
	assign ge_low  = (acc_cmp >= low_th);
	assign le_high = (acc_cmp <= high_th);
	assign le_up   = (acc_cmp <= up_th);
	assign hit     = ge_low && (le_high || le_up);
	assign band    = le_high ? BAND_BASKET : BAND_ABOVE;

	// Floor to millimetres, add the translation, saturate.
	assign sum_x = {acc_x[ACC_W-1], (acc_x >>> FRAC_BITS)}
		+ {{(SUM_W-TRANS_BITS){tx[TRANS_BITS-1]}}, tx};
	assign sum_y = {acc_y[ACC_W-1], (acc_y >>> FRAC_BITS)}
		+ {{(SUM_W-TRANS_BITS){ty[TRANS_BITS-1]}}, ty};
	assign sum_z = {acc_z[ACC_W-1], (acc_z >>> FRAC_BITS)}
		+ {{(SUM_W-TRANS_BITS){tz[TRANS_BITS-1]}}, tz};

	assign world_x = sat_out(sum_x);
	assign world_y = sat_out(sum_y);
	assign world_z = sat_out(sum_z);

endmodule

`default_nettype wire

/* rtl/core/point_height_band_classifier.sv */
// Classifies camera depth points by world height. One point item is taken per
// clock cycle when the result side keeps up; a point that survives decimation
// and the validity check passes through four register stages (input register,
// product register, row-sum register, result register) before any result item
// appears. The nine rotation multipliers of the product stage set the clock;
// the only state carried from point to point is the decimation counter, which
// updates at the moment a point is taken.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and must only change while no point is in flight.
`default_nettype none

module point_height_band_classifier
	import phbc_pkg::*;
#(
	parameter int FRAC_BITS  = 16,
	parameter int COORD_BITS = 14
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	phbc_point_if.sink                    points,
	phbc_world_if.source                  hits
);

	localparam int PROD_W = COEF_BITS + COORD_BITS;
	localparam int ACC_W  = PROD_W + 2;

	cfg_t      cfg;
	pipe_ctl_t ctl;

	logic                         valid_s1, valid_s2, valid_s3;
	logic signed [COORD_BITS-1:0] px_s1, py_s1, pz_s1;
	logic [DEC_BITS-1:0]          skip_q;
	logic [DEC_BITS-1:0]          dec_eff;
	logic [DEC_BITS:0]            skip_inc;
	logic                         examine, accept;
	logic                         load1, res_ready;

	logic signed [ACC_W-1:0]      acc_x, acc_y, acc_z;
	logic                         hit, band;
	logic signed [OUT_BITS-1:0]   wx, wy, wz;

	logic                         res_valid_q;
	logic signed [OUT_BITS-1:0]   world_x_q, world_y_q, world_z_q;
	logic                         band_q;

	phbc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage enables: each stage loads when it is empty or its item moves on.
	assign res_ready   = !res_valid_q || hits.ready;
	assign ctl.s3_load = !valid_s3 || res_ready;
	assign ctl.s2_load = !valid_s2 || ctl.s3_load;
	assign load1       = !valid_s1 || ctl.s2_load;
	assign points.ready = load1;
	assign accept      = points.valid && load1;

	// Decimation counter; invalid points count as well.
	assign examine  = (skip_q == '0);
	assign dec_eff  = (cfg.decimation == '0) ? DEC_BITS'(1) : cfg.decimation;
	assign skip_inc = {1'b0, skip_q} + (DEC_BITS+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
		end else if (accept) begin
			if (skip_inc >= {1'b0, dec_eff} || points.last_point) begin
				skip_q <= '0;
			end else begin
				skip_q <= skip_inc[DEC_BITS-1:0];
			end
		end
	end

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load1) begin
				valid_s1 <= points.valid && examine && !points.point_invalid;
			end
			if (ctl.s2_load) begin
				valid_s2 <= valid_s1;
			end
			if (ctl.s3_load) begin
				valid_s3 <= valid_s2;
			end
			if (res_ready) begin
				res_valid_q <= valid_s3 && hit;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= points.point_x;
			py_s1 <= points.point_y;
			pz_s1 <= points.point_z;
		end
	end

	phbc_xform #(
		.COORD_BITS (COORD_BITS),
		.PROD_W     (PROD_W),
		.ACC_W      (ACC_W)
	) u_xform (
		.clk   (clk),
		.ctl   (ctl),
		.cfg   (cfg),
		.px    (px_s1),
		.py    (py_s1),
		.pz    (pz_s1),
		.acc_x (acc_x),
		.acc_y (acc_y),
		.acc_z (acc_z)
	);

	phbc_classify #(
		.FRAC_BITS (FRAC_BITS),
		.ACC_W     (ACC_W)
	) u_classify (
		.cfg     (cfg),
		.acc_x   (acc_x),
		.acc_y   (acc_y),
		.acc_z   (acc_z),
		.hit     (hit),
		.band    (band),
		.world_x (wx),
		.world_y (wy),
		.world_z (wz)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (res_ready) begin
			world_x_q <= wx;
			world_y_q <= wy;
			world_z_q <= wz;
			band_q    <= band;
		end
	end

	assign hits.valid   = res_valid_q;
	assign hits.world_x = world_x_q;
	assign hits.world_y = world_y_q;
	assign hits.world_z = world_z_q;
	assign hits.band    = band_q;

endmodule

`default_nettype wire

/* tb/band_hit_check.sv */
`timescale 1ns / 100ps

// Watches the point and result channels of the classifier, keeps its own copy
// of the register file and the decimation position, predicts each result item
// and compares it field by field with what the block delivers.
module band_hit_check
	import phbc_pkg::*;
#(
	parameter int FRAC_BITS  = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	phbc_point_if                    points,
	phbc_world_if                    hits,
	output int                       mismatches,
	output int                       outstanding,
	output int                       hits_seen,
	output int                       above_seen
);

	localparam longint ONE    = longint'(1) << FRAC_BITS;
	localparam longint OUT_HI = (longint'(1) << (OUT_BITS - 1)) - 1;
	localparam longint OUT_LO = -(longint'(1) << (OUT_BITS - 1));

	typedef struct packed {
		logic signed [OUT_BITS-1:0] world_x;
		logic signed [OUT_BITS-1:0] world_y;
		logic signed [OUT_BITS-1:0] world_z;
		logic                       band;
	} world_item_t;

	world_item_t         expected_hits[$];
	cfg_t                regs;
	logic [DEC_BITS-1:0] decim_phase;

	// Signed coefficient k of a packed rotation row.
	function automatic longint coef_at(logic [ROW_BITS-1:0] row, int k);
		logic signed [COEF_BITS-1:0] c;
		c = row[k*COEF_BITS +: COEF_BITS];
		return longint'(c);
	endfunction

	function automatic longint row_dot(logic [ROW_BITS-1:0] row, longint x, longint y,
			longint z);
		return coef_at(row, 0) * x + coef_at(row, 1) * y + coef_at(row, 2) * z;
	endfunction

	// Signed translation k (x, y, z) in millimetres.
	function automatic longint xlat_at(int k);
		logic signed [TRANS_BITS-1:0] t;
		t = regs.translation[k*TRANS_BITS +: TRANS_BITS];
		return longint'(t);
	endfunction

	// Floor of the Q accumulator, plus translation, saturated to the output width.
	function automatic logic signed [OUT_BITS-1:0] to_mm(longint acc, longint offset);
		longint v;
		v = (acc >>> FRAC_BITS) + offset;
		if (v > OUT_HI) begin
			v = OUT_HI;
		end else if (v < OUT_LO) begin
			v = OUT_LO;
		end
		return v[OUT_BITS-1:0];
	endfunction

	task automatic report(string msg);
		$display("[%0t] hit check: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic signed [OUT_BITS-1:0] got,
			logic signed [OUT_BITS-1:0] want);
		if (got !== want) begin
			report($sformatf("result %0d %s is %0d, expected %0d", hits_seen, name, got, want));
		end
	endtask

	// Advances the decimation position and queues the result the point causes, if any.
	task automatic classify_point(longint x, longint y, longint z, logic invalid,
			logic is_last);
		longint      dec, az, low, high, ceiling;
		logic        examine;
		world_item_t w;
		examine = (decim_phase == '0);
		dec = (regs.decimation == '0) ? 1 : longint'(regs.decimation);
		if (is_last || longint'(decim_phase) + 1 >= dec) begin
			decim_phase = '0;
		end else begin
			decim_phase = decim_phase + 1'b1;
		end
		if (!examine || invalid) begin
			return;
		end

		// Height is compared at full precision against the scaled thresholds.
		az      = row_dot(regs.rot_row_z, x, y, z);
		low     = (longint'(regs.band_low) - xlat_at(2)) * ONE;
		high    = (longint'(regs.band_high) - xlat_at(2)) * ONE;
		ceiling = high + longint'(regs.upper_margin >> 1) * ONE;
		if (az < low || az > ceiling) begin
			return;
		end
		w.band    = (az <= high) ? BAND_BASKET : BAND_ABOVE;
		w.world_x = to_mm(row_dot(regs.rot_row_x, x, y, z), xlat_at(0));
		w.world_y = to_mm(row_dot(regs.rot_row_y, x, y, z), xlat_at(1));
		w.world_z = to_mm(az, xlat_at(2));
		expected_hits.insert(expected_hits.size(), w);
	endtask

	always @(posedge clk or negedge arst_n) begin
		world_item_t got, want;
		if (!arst_n) begin
			regs.rot_row_x    = RST_ROT_ROW_X;
			regs.rot_row_y    = RST_ROT_ROW_Y;
			regs.rot_row_z    = RST_ROT_ROW_Z;
			regs.translation  = RST_TRANSLATION;
			regs.band_low     = RST_BAND_LOW;
			regs.band_high    = RST_BAND_HIGH;
			regs.upper_margin = RST_UPPER_MARGIN;
			regs.decimation   = RST_DECIMATION;
			decim_phase       = '0;
			expected_hits.delete();
			mismatches        = 0;
			hits_seen         = 0;
			above_seen        = 0;
		end else begin
			// A result item is matched against the oldest expectation first, since
			// it can never belong to a point taken at the same edge.
			if (hits.valid && hits.ready) begin
				got.world_x = hits.world_x;
				got.world_y = hits.world_y;
				got.world_z = hits.world_z;
				got.band    = hits.band;
				hits_seen++;
				if (got.band === BAND_ABOVE) begin
					above_seen++;
				end
				if (expected_hits.size() == 0) begin
					report($sformatf("unexpected result x %0d y %0d z %0d band %0d",
						got.world_x, got.world_y, got.world_z, got.band));
				end else begin
					want = expected_hits.pop_front();
					check_field("world_x", got.world_x, want.world_x);
					check_field("world_y", got.world_y, want.world_y);
					check_field("world_z", got.world_z, want.world_z);
					check_field("band", OUT_BITS'(got.band), OUT_BITS'(want.band));
				end
			end

			// Register writes go into the local copy.
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_ROT_ROW_X:    regs.rot_row_x    = cfg_data[ROW_BITS-1:0];
					REG_ROT_ROW_Y:    regs.rot_row_y    = cfg_data[ROW_BITS-1:0];
					REG_ROT_ROW_Z:    regs.rot_row_z    = cfg_data[ROW_BITS-1:0];
					REG_TRANSLATION:  regs.translation  = cfg_data[XLAT_BITS-1:0];
					REG_BAND_LOW:     regs.band_low     = cfg_data[BAND_BITS-1:0];
					REG_BAND_HIGH:    regs.band_high    = cfg_data[BAND_BITS-1:0];
					REG_UPPER_MARGIN: regs.upper_margin = cfg_data[MARGIN_BITS-1:0];
					REG_DECIMATION:   regs.decimation   = cfg_data[DEC_BITS-1:0];
					default: ;
				endcase
			end

			// Every accepted point item moves the model on.
			if (points.valid && points.ready) begin
				classify_point(longint'(points.point_x), longint'(points.point_y),
					longint'(points.point_z), points.point_invalid, points.last_point);
			end
		end
		outstanding = expected_hits.size();
	end

endmodule

/* tb/point_height_band_classifier_tb.sv */
`timescale 1ns / 100ps

// Drives point items and register settings into the classifier and gives the
// verdict; prediction and comparison live in band_hit_check.
module point_height_band_classifier_tb;
	import phbc_pkg::*;

	localparam int FRAC_BITS       = 16;
	localparam int COORD_BITS      = 14;
	localparam int COEF_MAX        = (1 << (COEF_BITS - 1)) - 1;
	localparam int COEF_MIN        = -(1 << (COEF_BITS - 1));
	localparam int COORD_MAX       = (1 << (COORD_BITS - 1)) - 1;
	localparam int COORD_MIN       = -(1 << (COORD_BITS - 1));
	localparam int BAND_MAX        = (1 << (BAND_BITS - 1)) - 1;
	localparam int BAND_MIN        = -(1 << (BAND_BITS - 1));
	localparam int MARGIN_MAX      = (1 << MARGIN_BITS) - 1;
	localparam int TRANS_MAX       = (1 << (TRANS_BITS - 1)) - 1;
	localparam int TRANS_MIN       = -(1 << (TRANS_BITS - 1));
	localparam int Q_ONE           = 1 << FRAC_BITS;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 105;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 12;
	localparam int DRAIN_LIMIT     = 5000;
	localparam int RUN_LIMIT       = 600000;

	// Shapes of a random register setting.
	typedef enum int {
		MIX_NEAR,
		MIX_RAW,
		MIX_WIDE
	} mix_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	int                       mismatches;
	int                       outstanding;
	int                       hits_seen;
	int                       above_seen;
	int                       points_sent = 0;
	int                       settings_loaded = 0;
	int unsigned              cycle_count = 0;
	bit                       calm = 1'b0;
	bit                       pressure_on = 1'b0;

	phbc_point_if #(.COORD_BITS(COORD_BITS)) points_ch ();
	phbc_world_if                            hits_ch ();

	point_height_band_classifier #(
		.FRAC_BITS (FRAC_BITS),
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.points   (points_ch),
		.hits     (hits_ch)
	);

	band_hit_check #(
		.FRAC_BITS (FRAC_BITS)
	) hit_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.points     (points_ch),
		.hits       (hits_ch),
		.mismatches (mismatches),
		.outstanding(outstanding),
		.hits_seen  (hits_seen),
		.above_seen (above_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, outstanding);
			$display("point_height_band_classifier verification failed");
			$finish;
		end
	end

	function automatic int span_rand(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ROW_BITS-1:0] pack_row(int cx, int cy, int cz);
		logic signed [COEF_BITS-1:0] a, b, c;
		a = COEF_BITS'(cx);
		b = COEF_BITS'(cy);
		c = COEF_BITS'(cz);
		return {c, b, a};
	endfunction

	function automatic logic [XLAT_BITS-1:0] pack_xlat(int tx, int ty, int tz);
		logic signed [TRANS_BITS-1:0] a, b, c;
		a = TRANS_BITS'(tx);
		b = TRANS_BITS'(ty);
		c = TRANS_BITS'(tz);
		return {c, b, a};
	endfunction

	function automatic cfg_t reset_settings();
		cfg_t s;
		s.rot_row_x    = RST_ROT_ROW_X;
		s.rot_row_y    = RST_ROT_ROW_Y;
		s.rot_row_z    = RST_ROT_ROW_Z;
		s.translation  = RST_TRANSLATION;
		s.band_low     = RST_BAND_LOW;
		s.band_high    = RST_BAND_HIGH;
		s.upper_margin = RST_UPPER_MARGIN;
		s.decimation   = RST_DECIMATION;
		return s;
	endfunction

	function automatic cfg_t random_settings(mix_t mix, int dec_lo, int dec_hi);
		cfg_t          s;
		logic [287:0]  raw;
		case (mix)
			// Close to identity, with a band that real points can reach.
			MIX_NEAR: begin
				s.rot_row_x = pack_row(Q_ONE + span_rand(-2000, 2000),
					span_rand(-3000, 3000), span_rand(-3000, 3000));
				s.rot_row_y = pack_row(span_rand(-3000, 3000),
					Q_ONE + span_rand(-2000, 2000), span_rand(-3000, 3000));
				s.rot_row_z = pack_row(span_rand(-3000, 3000), span_rand(-3000, 3000),
					Q_ONE + span_rand(-2000, 2000));
				s.translation = pack_xlat(span_rand(-500, 500), span_rand(-500, 500),
					span_rand(-500, 500));
				s.band_low     = BAND_BITS'(span_rand(-3000, 3000));
				s.band_high    = BAND_BITS'(int'(s.band_low) + span_rand(0, 1500));
				s.upper_margin = MARGIN_BITS'(($urandom_range(0, 4) == 0) ? 0
					: span_rand(1, 400));
			end
			// Large horizontal coefficients and offsets drive x and y into saturation,
			// while the widest band keeps nearly every point.
			MIX_WIDE: begin
				s.rot_row_x = pack_row(span_rand(COEF_MIN, COEF_MAX),
					span_rand(COEF_MIN, COEF_MAX), span_rand(COEF_MIN, COEF_MAX));
				s.rot_row_y = pack_row(span_rand(COEF_MIN, COEF_MAX),
					span_rand(COEF_MIN, COEF_MAX), span_rand(COEF_MIN, COEF_MAX));
				s.rot_row_z = pack_row(span_rand(-50, 50), span_rand(-50, 50),
					Q_ONE + span_rand(-100, 100));
				s.translation = pack_xlat(span_rand(TRANS_MIN, TRANS_MAX),
					span_rand(TRANS_MIN, TRANS_MAX), 0);
				s.band_low     = BAND_BITS'(BAND_MIN);
				s.band_high    = BAND_BITS'(BAND_MAX);
				s.upper_margin = MARGIN_BITS'(MARGIN_MAX);
			end
			// Every register bit but the decimation at random; results are rare here.
			default: begin
				raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom};
				s = raw[$bits(cfg_t)-1:0];
			end
		endcase
		s.decimation = DEC_BITS'(span_rand(dec_lo, dec_hi));
		return s;
	endfunction

	// Writes every register in index order; bits above a register's width carry junk.
	task automatic load_config(cfg_t s);
		cfg_reg_t                 idx;
		logic [CFG_DATA_BITS-1:0] value;
		idx = idx.first();
		do begin
			value = CFG_DATA_BITS'({$urandom, $urandom});
			case (idx)
				REG_ROT_ROW_X:    value = s.rot_row_x;
				REG_ROT_ROW_Y:    value = s.rot_row_y;
				REG_ROT_ROW_Z:    value = s.rot_row_z;
				REG_TRANSLATION:  value[XLAT_BITS-1:0] = s.translation;
				REG_BAND_LOW:     value[BAND_BITS-1:0] = s.band_low;
				REG_BAND_HIGH:    value[BAND_BITS-1:0] = s.band_high;
				REG_UPPER_MARGIN: value[MARGIN_BITS-1:0] = s.upper_margin;
				REG_DECIMATION:   value[DEC_BITS-1:0] = s.decimation;
				default: ;
			endcase
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= value;
			@(posedge clk);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	// Offers one point item after an optional gap and returns on the edge that takes it.
	task automatic send_point(int x, int y, int z, logic invalid, logic is_last);
		int idle;
		idle = idle_len();
		if (idle > 0) begin
			points_ch.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		points_ch.valid         <= 1'b1;
		points_ch.point_x       <= x[COORD_BITS-1:0];
		points_ch.point_y       <= y[COORD_BITS-1:0];
		points_ch.point_z       <= z[COORD_BITS-1:0];
		points_ch.point_invalid <= invalid;
		points_ch.last_point    <= is_last;
		do @(posedge clk); while (!points_ch.ready);
		points_sent++;
	endtask

	// In the near mix most points aim at the height band of the current setting; the rest are raw.
	task automatic send_random_point(cfg_t s, mix_t mix, int last_odds);
		int                           x, y, z, lo, hi;
		logic signed [TRANS_BITS-1:0] tz;
		logic                         invalid, is_last;
		invalid = ($urandom_range(0, 9) == 0);
		is_last = ($urandom_range(1, last_odds) == 1);
		x = $urandom;
		y = $urandom;
		z = $urandom;
		if (mix == MIX_NEAR && $urandom_range(0, 3) != 0) begin
			tz = s.translation[2*TRANS_BITS +: TRANS_BITS];
			lo = int'(s.band_low) - 40;
			hi = int'(s.band_high) + int'(s.upper_margin) / 2 + 40;
			z  = span_rand(lo, hi) - int'(tz);
			if (z > COORD_MAX) begin
				z = COORD_MAX;
			end else if (z < COORD_MIN) begin
				z = COORD_MIN;
			end
			x = span_rand(-2000, 2000);
			y = span_rand(-2000, 2000);
		end
		send_point(x, y, z, invalid, is_last);
	endtask

	// Stops offering, waits for every expected result and lets the pipeline empty.
	task automatic drain_and_idle();
		int guard;
		guard = 0;
		points_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result side: random stalls, one long hold-off while points keep coming.
	initial begin
		bit held;
		int stall;
		held          = 1'b0;
		hits_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (pressure_on && !held) begin
				held = 1'b1;
				hits_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = idle_len();
				if (stall > 0) begin
					hits_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				hits_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	// Stimulus: directed cases, then random register settings and points.
	initial begin
		cfg_t s;
		mix_t mix;
		int   last_odds;
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = REG_ROT_ROW_X;
		cfg_data                = '0;
		points_ch.valid         = 1'b0;
		points_ch.point_x       = '0;
		points_ch.point_y       = '0;
		points_ch.point_z       = '0;
		points_ch.point_invalid = 1'b0;
		points_ch.last_point    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: the band edges, the above-basket edge and the coordinate extremes.
		send_point(COORD_MIN, COORD_MAX, 700, 1'b0, 1'b0);
		send_point(COORD_MAX, COORD_MIN, 699, 1'b0, 1'b0);
		send_point(0, 0, 1000, 1'b0, 1'b0);
		send_point(1, -1, 1015, 1'b0, 1'b0);
		send_point(0, 0, 1016, 1'b0, 1'b0);
		send_point(5, 5, 800, 1'b1, 1'b0);
		send_point(0, 0, COORD_MIN, 1'b0, 1'b0);
		send_point(0, 0, COORD_MAX, 1'b0, 1'b0);
		send_point(-1, -1, 1001, 1'b0, 1'b1);
		send_point(100, 200, 850, 1'b0, 1'b0);

		// Keep one point in three (the frame end falls where the count restarts anyway),
		// and an invalid point on an examined slot is not replaced by its successor.
		drain_and_idle();
		s            = reset_settings();
		s.band_low   = BAND_BITS'(BAND_MIN);
		s.band_high  = BAND_BITS'(BAND_MAX);
		s.decimation = DEC_BITS'(3);
		load_config(s);
		send_point(1, 2, 10, 1'b0, 1'b0);
		send_point(1, 2, 20, 1'b0, 1'b0);
		send_point(1, 2, 30, 1'b0, 1'b1);
		send_point(1, 2, 40, 1'b0, 1'b0);
		send_point(1, 2, 50, 1'b0, 1'b0);
		send_point(1, 2, 60, 1'b0, 1'b0);
		send_point(1, 2, 70, 1'b1, 1'b0);
		send_point(1, 2, 80, 1'b0, 1'b0);

		// Extreme coefficients and translations saturate x and y; a decimation of
		// zero keeps every point.
		drain_and_idle();
		s              = reset_settings();
		s.rot_row_x    = pack_row(COEF_MAX, COEF_MAX, COEF_MAX);
		s.rot_row_y    = pack_row(COEF_MIN, COEF_MIN, COEF_MIN);
		s.translation  = pack_xlat(TRANS_MAX, TRANS_MIN, 0);
		s.band_low     = BAND_BITS'(BAND_MIN);
		s.band_high    = BAND_BITS'(BAND_MAX);
		s.upper_margin = MARGIN_BITS'(MARGIN_MAX);
		s.decimation   = '0;
		load_config(s);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
		send_point(0, 0, 0, 1'b0, 1'b0);
		send_point(COORD_MAX, COORD_MIN, 1, 1'b0, 1'b1);

		// Low threshold above the high one: only above-basket points survive.
		drain_and_idle();
		s              = reset_settings();
		s.band_low     = BAND_BITS'(500);
		s.band_high    = BAND_BITS'(400);
		s.upper_margin = MARGIN_BITS'(MARGIN_MAX);
		load_config(s);
		send_point(0, 0, 450, 1'b0, 1'b0);
		send_point(0, 0, 500, 1'b0, 1'b0);
		send_point(0, 0, 4495, 1'b0, 1'b0);
		send_point(0, 0, 4496, 1'b0, 1'b0);

		// Random phases, each with its own register setting.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_and_idle();
			calm      = 1'b0;
			last_odds = 24;
			case (p)
				0: begin
					mix  = MIX_NEAR;
					s    = random_settings(mix, 1, 1);
					calm = 1'b1;
				end
				1: begin
					mix = MIX_NEAR;
					s   = random_settings(mix, 2, 6);
				end
				2: begin
					mix = MIX_RAW;
					s   = random_settings(mix, 0, 255);
				end
				3: begin
					mix       = MIX_NEAR;
					s         = random_settings(mix, 255, 255);
					last_odds = 3;
				end
				4: begin
					mix = MIX_WIDE;
					s   = random_settings(mix, 0, 0);
				end
				default: begin
					mix = MIX_NEAR;
					s   = random_settings(mix, 1, 4);
				end
			endcase
			load_config(s);
			if (p == 1) begin
				pressure_on = 1'b1;
			end
			repeat (ITEMS_PER_PHASE) send_random_point(s, mix, last_odds);
		end

		drain_and_idle();
		$display("Sent %0d points under %0d register settings besides reset values.",
			points_sent, settings_loaded);
		$display("Checked %0d results, %0d of them in the above-basket band.",
			hits_seen, above_seen);
		if (outstanding != 0) begin
			$display("%0d expected results never arrived.", outstanding);
		end
		if (mismatches == 0 && outstanding == 0) begin
			$display("point_height_band_classifier verification clean");
		end else begin
			$display("point_height_band_classifier verification failed");
		end
		$finish;
	end

endmodule
